@@ src/arm_instruction_field_decoder_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the ARM instruction field decoder checks
// ---------------------------------------------------------------------------
`ifndef ARM_INSTRUCTION_FIELD_DECODER_ASSERT_SVH
`define ARM_INSTRUCTION_FIELD_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define AIFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aifd check failed");

// next-cycle implication, disabled in reset
`define AIFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aifd check failed");

`endif

@@ src/aifd_pkg.sv @@
// ---------------------------------------------------------------------------
// aifd_pkg
// Codes, result type and decode function for the instruction field decoder.
// ---------------------------------------------------------------------------
package aifd_pkg;

    localparam logic [3:0] OP_ADD     = 4'd0;
    localparam logic [3:0] OP_SUB     = 4'd1;
    localparam logic [3:0] OP_AND     = 4'd2;
    localparam logic [3:0] OP_ORR     = 4'd3;
    localparam logic [3:0] OP_EOR     = 4'd4;
    localparam logic [3:0] OP_MOV     = 4'd5;
    localparam logic [3:0] OP_CMP     = 4'd6;
    localparam logic [3:0] OP_LDR     = 4'd7;
    localparam logic [3:0] OP_STR     = 4'd8;
    localparam logic [3:0] OP_B       = 4'd9;
    localparam logic [3:0] OP_BL      = 4'd10;
    localparam logic [3:0] OP_INVALID = 4'd11;

    // data-processing opcode field values
    localparam logic [3:0] DP_ADD = 4'b0100;
    localparam logic [3:0] DP_SUB = 4'b0010;
    localparam logic [3:0] DP_AND = 4'b0000;
    localparam logic [3:0] DP_ORR = 4'b1100;
    localparam logic [3:0] DP_EOR = 4'b0001;
    localparam logic [3:0] DP_MOV = 4'b1101;
    localparam logic [3:0] DP_CMP = 4'b1010;

    // instruction class, bits 27:25
    localparam logic [2:0] CLS_DP_REG  = 3'b000;
    localparam logic [2:0] CLS_DP_IMM  = 3'b001;
    localparam logic [2:0] CLS_MEM_IMM = 3'b010;
    localparam logic [2:0] CLS_MEM_REG = 3'b011;
    localparam logic [2:0] CLS_BRANCH  = 3'b101;

    localparam int DATA_W = 64;
    localparam int USER_W = 4;

    typedef struct packed {
        logic [3:0]  operation;
        logic [3:0]  condition;
        logic        set_flags;
        logic [3:0]  base_reg;
        logic [3:0]  dest_reg;
        logic [31:0] immediate;
        logic        shift_used;
        logic [3:0]  shift_reg;
        logic [1:0]  shift_kind;
        logic [4:0]  shift_amount;
        logic [2:0]  index_flags;
    } result_t;

    function automatic logic [3:0] dp_map(input logic [3:0] code);
        logic [3:0] op;
        case (code)
            DP_ADD:  op = OP_ADD;
            DP_SUB:  op = OP_SUB;
            DP_AND:  op = OP_AND;
            DP_ORR:  op = OP_ORR;
            DP_EOR:  op = OP_EOR;
            DP_MOV:  op = OP_MOV;
            DP_CMP:  op = OP_CMP;
            default: op = OP_INVALID;
        endcase
        return op;
    endfunction

    function automatic result_t decode(input logic [31:0] w);
        result_t     r;
        logic [31:0] byte_ext;
        logic [4:0]  rot;
        logic [5:0]  rot_inv;
        logic [31:0] off;
        r        = '0;
        byte_ext = {24'd0, w[7:0]};
        rot      = {w[11:8], 1'b0};
        rot_inv  = 6'd32 - {1'b0, rot};
        off      = {{8{w[23]}}, w[23:0]};
        case (w[27:25]) inside
            CLS_DP_REG, CLS_DP_IMM:
            begin
                r.condition = w[31:28];
                r.set_flags = w[20];
                r.base_reg  = w[19:16];
                r.dest_reg  = w[15:12];
                r.operation = dp_map(w[24:21]);
                if (w[25])
                begin
                    if (rot == 5'd0)
                        r.immediate = byte_ext;
                    else
                        r.immediate = (byte_ext >> rot) | (byte_ext << rot_inv);
                end
                else
                begin
                    r.shift_used   = 1'b1;
                    r.shift_reg    = w[3:0];
                    r.shift_kind   = w[6:5];
                    r.shift_amount = w[11:7];
                end
            end
            CLS_MEM_IMM, CLS_MEM_REG:
            begin
                r.condition   = w[31:28];
                r.set_flags   = w[20];
                r.base_reg    = w[19:16];
                r.dest_reg    = w[15:12];
                r.operation   = w[20] ? OP_LDR : OP_STR;
                r.index_flags = {w[21], w[23], w[24]};
                if (w[25])
                begin
                    r.shift_used   = 1'b1;
                    r.shift_reg    = w[3:0];
                    r.shift_kind   = w[6:5];
                    r.shift_amount = w[11:7];
                end
                else
                    r.immediate = {20'd0, w[11:0]};
            end
            CLS_BRANCH:
            begin
                r.condition = w[31:28];
                r.operation = w[24] ? OP_BL : OP_B;
                r.immediate = {off[29:0], 2'b00};
            end
            default:
                r.operation = OP_INVALID;
        endcase
        return r;
    endfunction

endpackage

@@ src/arm_instruction_field_decoder.sv @@
// ---------------------------------------------------------------------------
// arm_instruction_field_decoder
// Splits 32-bit ARM instruction words into their decoded fields.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one instruction word per transfer; m_axis returns one
//   decoded result per word, in order. tuser on m_axis is the operation.
//   An accepted word passes through the input register, decode logic and
//   result register before its result appears on m_axis.
//   Throughput: one word per cycle when not stalled; input and result registers
//   form a two-deep pipeline, so a new word is taken while a result waits.
//   Stall: when m_axis_tready is low the result holds and the pipeline
//   fills; s_axis_tready drops only when both stages are occupied.
//   Reset: rst_n low empties both stages; no results are pending after it.
// ---------------------------------------------------------------------------
module arm_instruction_field_decoder
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // instruction_word
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // condition, set_flags, base_reg, dest_reg, immediate, shift_used,
    // shift_reg, shift_kind, shift_amount, index_flags, zero pad
    output logic [aifd_pkg::DATA_W-1:0]  m_axis_tdata,
    output logic [aifd_pkg::USER_W-1:0]  m_axis_tuser   // operation
);

    logic              in_valid_reg;
    logic [31:0]       in_word_reg;
    logic              out_valid_reg;
    aifd_pkg::result_t out_reg;
    aifd_pkg::result_t out_next;
    logic              out_adv;

    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || out_adv;
    assign out_next      = aifd_pkg::decode(in_word_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_word_reg <= s_axis_tdata;
        if (out_adv && in_valid_reg)
            out_reg <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.operation;
    assign m_axis_tdata  = {4'd0, out_reg.index_flags, out_reg.shift_amount,
                            out_reg.shift_kind, out_reg.shift_reg, out_reg.shift_used,
                            out_reg.immediate, out_reg.dest_reg, out_reg.base_reg,
                            out_reg.set_flags, out_reg.condition};

endmodule

@@ src/aifd_checker.sv @@
// ---------------------------------------------------------------------------
// aifd_checker
// Port-level checks on the decoder's result stream.
// ---------------------------------------------------------------------------
`include "arm_instruction_field_decoder_assert.svh"

module aifd_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [aifd_pkg::DATA_W-1:0]  m_axis_tdata,
    input logic [aifd_pkg::USER_W-1:0]  m_axis_tuser
);

    logic                                        out_stall;
    logic [aifd_pkg::USER_W+aifd_pkg::DATA_W-1:0] out_word;
    logic                                        shift_used;
    logic [10:0]                                 shift_fields;
    logic                                        index_set;
    logic                                        is_mem;
    logic                                        is_branch;
    logic                                        branch_clear;

    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign out_word     = {m_axis_tuser, m_axis_tdata};
    assign shift_used   = m_axis_tdata[45];
    assign shift_fields = m_axis_tdata[56:46];
    assign index_set    = m_axis_tdata[59:57] != 3'd0;
    assign is_mem       = (m_axis_tuser == aifd_pkg::OP_LDR) ||
                          (m_axis_tuser == aifd_pkg::OP_STR);
    assign is_branch    = (m_axis_tuser == aifd_pkg::OP_B) ||
                          (m_axis_tuser == aifd_pkg::OP_BL);
    assign branch_clear = (m_axis_tdata[14:4] == 11'd0) && (m_axis_tdata[63:45] == 19'd0);

    `AIFD_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))
    `AIFD_ASSERT_NOW(a_shift_zero, clk, rst_n, m_axis_tvalid && !shift_used, shift_fields == 11'd0)
    `AIFD_ASSERT_NOW(a_index_mem, clk, rst_n, m_axis_tvalid && index_set, is_mem)
    `AIFD_ASSERT_NOW(a_branch_fields, clk, rst_n, m_axis_tvalid && is_branch, branch_clear)

endmodule

bind arm_instruction_field_decoder aifd_checker u_aifd_checker (.*);
